// File: rtl/svv_pkg.sv
`default_nettype none
package svv_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int STEP_W = 32;
    localparam int MASS_W = 31;
    localparam int QB     = 33;
    localparam int DV_W   = MASS_W + FRAC_W;
    localparam int DS_W   = 3 * MASS_W;
    localparam int NV_W   = 2 * STEP_W;
    localparam int NS_W   = NV_W + 3 + FRAC_W - 1;
    localparam int LAT    = 3 + QB + 3;

    typedef enum logic [1:0] {
        CFG_HALF_STEP = 2'd0,
        CFG_FULL_STEP = 2'd1,
        CFG_GROUP     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              func;
        logic [31:0]       group_mask;
        logic [MASS_W-1:0] mass;
        logic [MASS_W-1:0] radius;
        logic [WORD_W-1:0] position;
        logic [WORD_W-1:0] velocity;
        logic [WORD_W-1:0] force_req;
        logic [WORD_W-1:0] spin;
        logic [WORD_W-1:0] torque_in;
    } request_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_position;
        logic [WORD_W-1:0] new_velocity;
        logic [WORD_W-1:0] new_spin;
        logic              overflow;
    } result_t;

    typedef struct packed {
        logic              func;
        logic              in_grp;
        logic [WORD_W-1:0] position;
        logic [WORD_W-1:0] velocity;
        logic [WORD_W-1:0] spin;
        logic              f_neg;
        logic              t_neg;
        logic              sat_v;
        logic              sat_s;
    } pass_t;

    typedef struct packed {
        logic            valid;
        pass_t           pass;
        logic [DV_W-1:0] d_v;
        logic [DS_W-1:0] d_s;
        logic [DV_W-1:0] rem_v;
        logic [DS_W-1:0] rem_s;
        logic [QB-1:0]   nb_v;
        logic [QB-1:0]   nb_s;
        logic [QB-1:0]   q_v;
        logic [QB-1:0]   q_s;
    } cell_t;

    function automatic logic [WORD_W-1:0] abs_w(input logic [WORD_W-1:0] x);
        abs_w = x[WORD_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Returns the overflow flag above the saturated sum.
    function automatic logic [WORD_W:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic neg,
                                                input logic [WORD_W:0] mag);
        logic [WORD_W+1:0] off;
        logic [WORD_W+1:0] sum;
        logic              ovf;
        logic [WORD_W-1:0] val;
        off = {2'b00, a ^ {1'b1, {(WORD_W-1){1'b0}}}};
        ovf = 1'b0;
        if (!neg)
        begin
            sum = off + {1'b0, mag};
            if (sum[WORD_W+1:WORD_W] != 2'b00)
            begin
                ovf = 1'b1;
                val = {WORD_W{1'b1}};
            end
            else
            begin
                val = sum[WORD_W-1:0];
            end
        end
        else
        begin
            sum = off - {1'b0, mag};
            if ({1'b0, mag} > off)
            begin
                ovf = 1'b1;
                val = {WORD_W{1'b0}};
            end
            else
            begin
                val = sum[WORD_W-1:0];
            end
        end
        sat_add = {ovf, val ^ {1'b1, {(WORD_W-1){1'b0}}}};
    endfunction

endpackage
`default_nettype wire

// File: rtl/svv_front.sv
`default_nettype none
module svv_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire svv_pkg::request_t request,
    input  wire logic [31:0]       half_step,
    input  wire logic [31:0]       group_select,
    output svv_pkg::cell_t         cell_out
);

    typedef struct packed {
        svv_pkg::pass_t                  pass;
        logic [svv_pkg::MASS_W-1:0]      mass;
        logic [svv_pkg::MASS_W-1:0]      radius;
        logic [svv_pkg::NV_W-1:0]        p_vf;
        logic [svv_pkg::NV_W-1:0]        p_vt;
        logic [2*svv_pkg::MASS_W-1:0]    p_mr;
    } s1_t;

    typedef struct packed {
        svv_pkg::pass_t                  pass;
        logic [svv_pkg::NV_W-1:0]        n_v;
        logic [svv_pkg::NS_W-1:0]        n_s;
        logic [svv_pkg::DV_W-1:0]        d_v;
        logic [2*svv_pkg::MASS_W-1:0]    pr_hi;
        logic [2*svv_pkg::MASS_W-1:0]    pr_lo;
    } s2_t;

    logic           s1_valid_reg, s1_valid_next;
    logic           s2_valid_reg, s2_valid_next;
    logic           s3_valid_reg, s3_valid_next;
    s1_t            s1_reg, s1_next;
    s2_t            s2_reg, s2_next;
    svv_pkg::cell_t s3_reg, s3_next;
    logic [svv_pkg::NV_W+2:0] t5;

    always_comb
    begin
        s1_valid_next         = start;
        s1_next.pass.func     = request.func;
        s1_next.pass.in_grp   = |(request.group_mask & group_select);
        s1_next.pass.position = request.position;
        s1_next.pass.velocity = request.velocity;
        s1_next.pass.spin     = request.spin;
        s1_next.pass.f_neg    = request.force_req[svv_pkg::WORD_W-1];
        s1_next.pass.t_neg    = request.torque_in[svv_pkg::WORD_W-1];
        s1_next.pass.sat_v    = 1'b0;
        s1_next.pass.sat_s    = 1'b0;
        s1_next.mass          = request.mass;
        s1_next.radius        = request.radius;
        s1_next.p_vf          = half_step * svv_pkg::abs_w(request.force_req);
        s1_next.p_vt          = half_step * svv_pkg::abs_w(request.torque_in);
        s1_next.p_mr          = request.mass * request.radius;
    end

    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        t5            = {3'b000, s1_reg.p_vt} + {1'b0, s1_reg.p_vt, 2'b00};
        s2_next.pass  = s1_reg.pass;
        s2_next.n_v   = s1_reg.p_vf;
        s2_next.n_s   = {t5, {(svv_pkg::FRAC_W-1){1'b0}}};
        s2_next.d_v   = {s1_reg.mass, {svv_pkg::FRAC_W{1'b0}}};
        s2_next.pr_hi = s1_reg.p_mr[2*svv_pkg::MASS_W-1:svv_pkg::MASS_W] * s1_reg.radius;
        s2_next.pr_lo = s1_reg.p_mr[svv_pkg::MASS_W-1:0] * s1_reg.radius;
    end

    always_comb
    begin
        s3_valid_next = s2_valid_reg;
        s3_next.valid = s2_valid_reg;
        s3_next.pass  = s2_reg.pass;
        s3_next.d_v   = s2_reg.d_v;
        s3_next.d_s   = {s2_reg.pr_hi, {svv_pkg::MASS_W{1'b0}}}
                      + {{svv_pkg::MASS_W{1'b0}}, s2_reg.pr_lo};
        s3_next.rem_v = {{(svv_pkg::DV_W-svv_pkg::NV_W+svv_pkg::QB){1'b0}},
                         s2_reg.n_v[svv_pkg::NV_W-1:svv_pkg::QB]};
        s3_next.rem_s = {{(svv_pkg::DS_W-svv_pkg::NS_W+svv_pkg::QB){1'b0}},
                         s2_reg.n_s[svv_pkg::NS_W-1:svv_pkg::QB]};
        s3_next.nb_v  = s2_reg.n_v[svv_pkg::QB-1:0];
        s3_next.nb_s  = s2_reg.n_s[svv_pkg::QB-1:0];
        s3_next.q_v   = '0;
        s3_next.q_s   = '0;
        if (s2_reg.d_v == '0)
        begin
            s3_next.pass.sat_v = |s2_reg.n_v;
        end
        else
        begin
            s3_next.pass.sat_v = (s3_next.rem_v >= s2_reg.d_v);
        end
        if (s3_next.d_s == '0)
        begin
            s3_next.pass.sat_s = |s2_reg.n_s;
        end
        else
        begin
            s3_next.pass.sat_s = (s3_next.rem_s >= s3_next.d_s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    always_comb
    begin
        cell_out       = s3_reg;
        cell_out.valid = s3_valid_reg;
    end

endmodule
`default_nettype wire

// File: rtl/svv_div_cell.sv
`default_nettype none
module svv_div_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire svv_pkg::cell_t cell_in,
    output svv_pkg::cell_t      cell_out
);

    logic           valid_reg, valid_next;
    svv_pkg::cell_t cell_reg, cell_next;
    logic [svv_pkg::DV_W:0] tv;
    logic [svv_pkg::DS_W:0] ts;
    logic [svv_pkg::DV_W:0] dv;
    logic [svv_pkg::DS_W:0] ds;
    logic                   bv, bs;

    always_comb
    begin
        valid_next = cell_in.valid;
        cell_next  = cell_in;
        tv = {cell_in.rem_v, cell_in.nb_v[svv_pkg::QB-1]};
        ts = {cell_in.rem_s, cell_in.nb_s[svv_pkg::QB-1]};
        bv = (tv >= {1'b0, cell_in.d_v});
        bs = (ts >= {1'b0, cell_in.d_s});
        dv = bv ? (tv - {1'b0, cell_in.d_v}) : tv;
        ds = bs ? (ts - {1'b0, cell_in.d_s}) : ts;
        cell_next.rem_v = dv[svv_pkg::DV_W-1:0];
        cell_next.rem_s = ds[svv_pkg::DS_W-1:0];
        cell_next.nb_v  = {cell_in.nb_v[svv_pkg::QB-2:0], 1'b0};
        cell_next.nb_s  = {cell_in.nb_s[svv_pkg::QB-2:0], 1'b0};
        cell_next.q_v   = {cell_in.q_v[svv_pkg::QB-2:0], bv};
        cell_next.q_s   = {cell_in.q_s[svv_pkg::QB-2:0], bs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    always_comb
    begin
        cell_out       = cell_reg;
        cell_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

// File: rtl/svv_back.sv
`default_nettype none
module svv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire svv_pkg::cell_t cell_in,
    input  wire logic [31:0]    full_step,
    output logic                done,
    output svv_pkg::result_t    result
);

    typedef struct packed {
        logic                        func;
        logic                        in_grp;
        logic [svv_pkg::WORD_W-1:0]  position;
        logic [svv_pkg::WORD_W-1:0]  velocity;
        logic [svv_pkg::WORD_W-1:0]  spin;
        logic                        ovf;
    } b1_t;

    typedef struct packed {
        b1_t                       b;
        logic [svv_pkg::NV_W-1:0]  p_pos;
    } b2_t;

    logic             b1_valid_reg, b1_valid_next;
    logic             b2_valid_reg, b2_valid_next;
    logic             done_reg, done_next;
    b1_t              b1_reg, b1_next;
    b2_t              b2_reg, b2_next;
    svv_pkg::result_t result_reg, result_next;
    logic [svv_pkg::QB-1:0]     mag_v, mag_s;
    logic [svv_pkg::WORD_W:0]   rv, rs, rp;

    // With a zero divisor the divider row settles to all ones; a zero dividend
    // then leaves the value unchanged, and a nonzero one is already saturated.
    always_comb
    begin
        b1_valid_next   = cell_in.valid;
        if (cell_in.pass.sat_v)
        begin
            mag_v = {svv_pkg::QB{1'b1}};
        end
        else if (cell_in.d_v == '0)
        begin
            mag_v = '0;
        end
        else
        begin
            mag_v = cell_in.q_v;
        end
        if (cell_in.pass.sat_s)
        begin
            mag_s = {svv_pkg::QB{1'b1}};
        end
        else if (cell_in.d_s == '0)
        begin
            mag_s = '0;
        end
        else
        begin
            mag_s = cell_in.q_s;
        end
        rv              = svv_pkg::sat_add(cell_in.pass.velocity, cell_in.pass.f_neg, mag_v);
        rs              = svv_pkg::sat_add(cell_in.pass.spin, cell_in.pass.t_neg, mag_s);
        b1_next.func     = cell_in.pass.func;
        b1_next.in_grp   = cell_in.pass.in_grp;
        b1_next.position = cell_in.pass.position;
        if (cell_in.pass.in_grp)
        begin
            b1_next.velocity = rv[svv_pkg::WORD_W-1:0];
            b1_next.spin     = rs[svv_pkg::WORD_W-1:0];
            b1_next.ovf      = rv[svv_pkg::WORD_W] | rs[svv_pkg::WORD_W];
        end
        else
        begin
            b1_next.velocity = cell_in.pass.velocity;
            b1_next.spin     = cell_in.pass.spin;
            b1_next.ovf      = 1'b0;
        end
    end

    always_comb
    begin
        b2_valid_next = b1_valid_reg;
        b2_next.b     = b1_reg;
        b2_next.p_pos = full_step * svv_pkg::abs_w(b1_reg.velocity);
    end

    always_comb
    begin
        done_next = b2_valid_reg;
        rp = svv_pkg::sat_add(b2_reg.b.position, b2_reg.b.velocity[svv_pkg::WORD_W-1],
                              {1'b0, b2_reg.p_pos[svv_pkg::NV_W-1:svv_pkg::STEP_W]});
        result_next.new_velocity = b2_reg.b.velocity;
        result_next.new_spin     = b2_reg.b.spin;
        if (b2_reg.b.in_grp && !b2_reg.b.func)
        begin
            result_next.new_position = rp[svv_pkg::WORD_W-1:0];
            result_next.overflow     = b2_reg.b.ovf | rp[svv_pkg::WORD_W];
        end
        else
        begin
            result_next.new_position = b2_reg.b.position;
            result_next.overflow     = b2_reg.b.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= b1_valid_next;
            b2_valid_reg <= b2_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg     <= b1_next;
        b2_reg     <= b2_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// File: rtl/sphere_velocity_verlet_step_unit.sv
`default_nettype none
// Velocity-Verlet half step for one axis of one sphere. A request is taken on
// every cycle in which start is high, since busy never rises, and its result
// appears with done after the front stages, the divider row and the back
// stages; done is high for one cycle and the result cannot be held back, so
// the receiver must take it then. The row has 33 divider cells, each settling
// one quotient bit of both the velocity and the spin kick, behind three stages
// of multipliers and ahead of three stages of saturation and position drift.
// Configuration must be written only while no request is in flight.
module sphere_velocity_verlet_step_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire svv_pkg::request_t request,
    input  wire logic              cfg_wen,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    output logic                   done,
    output svv_pkg::result_t       result
);

    logic [31:0] half_step_reg, half_step_next;
    logic [31:0] full_step_reg, full_step_next;
    logic [31:0] group_reg, group_next;
    svv_pkg::cell_t chain [0:svv_pkg::QB];

    always_comb
    begin
        half_step_next = half_step_reg;
        full_step_next = full_step_reg;
        group_next     = group_reg;
        if (cfg_wen)
        begin
            unique case (svv_pkg::cfg_idx_t'(cfg_index))
                svv_pkg::CFG_HALF_STEP: half_step_next = cfg_data;
                svv_pkg::CFG_FULL_STEP: full_step_next = cfg_data;
                svv_pkg::CFG_GROUP:     group_next     = cfg_data;
                default:                group_next     = group_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_step_reg <= 32'd0;
            full_step_reg <= 32'd0;
            group_reg     <= 32'd1;
        end
        else
        begin
            half_step_reg <= half_step_next;
            full_step_reg <= full_step_next;
            group_reg     <= group_next;
        end
    end

    assign busy = 1'b0;

    svv_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .half_step    (half_step_reg),
        .group_select (group_reg),
        .cell_out     (chain[0])
    );

    for (genvar i = 0; i < svv_pkg::QB; i++)
    begin : g_cell
        svv_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    svv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (chain[svv_pkg::QB]),
        .full_step (full_step_reg),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(svv_pkg::LAT) done)
        else $error("result did not follow its request at the fixed latency");

    a_rem_v: assert property (@(posedge clk) disable iff (!rst_n)
        (chain[svv_pkg::QB].valid && chain[svv_pkg::QB].pass.in_grp &&
         !chain[svv_pkg::QB].pass.sat_v && chain[svv_pkg::QB].d_v != '0)
        |-> (chain[svv_pkg::QB].rem_v < chain[svv_pkg::QB].d_v))
        else $error("velocity remainder not below its divisor");

    a_rem_s: assert property (@(posedge clk) disable iff (!rst_n)
        (chain[svv_pkg::QB].valid && chain[svv_pkg::QB].pass.in_grp &&
         !chain[svv_pkg::QB].pass.sat_s && chain[svv_pkg::QB].d_s != '0)
        |-> (chain[svv_pkg::QB].rem_s < chain[svv_pkg::QB].d_s))
        else $error("spin remainder not below its divisor");
`endif

endmodule
`default_nettype wire
